// File: rtl/fsme_pkg.sv
// shared constants and types for the flow-shop makespan evaluator
package fsme_pkg;

    localparam int MAX_JOBS     = 256;
    localparam int MAX_MACHINES = 32;
    localparam int TIME_WIDTH   = 16;

    localparam int JOB_W  = $clog2(MAX_JOBS);
    localparam int MACH_W = $clog2(MAX_MACHINES);
    localparam int ADDR_W = JOB_W + MACH_W;
    localparam int TT_DEPTH = MAX_JOBS * MAX_MACHINES;

    // port field widths
    localparam int JOB_ID_W   = 8;
    localparam int MACH_ID_W  = 5;
    localparam int PTIME_W    = 16;
    localparam int CFG_W      = 6;
    localparam int COMP_W     = 25;

    localparam logic [COMP_W-1:0] COMP_MAX = {COMP_W{1'b1}};

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SCHED = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } t_state;

endpackage

// File: rtl/fsme_ram.sv
// generic simple dual-port ram with registered read
module fsme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/flow_shop_makespan_evaluator.sv
// top level of the permutation flow-shop completion-time evaluator
// A write item (command 0) stores one processing time in the job x machine
// time table memory. A schedule item (command 1) walks
// machines 0 .. machine_count-1 in order; per machine it reads the time
// table and the previous-row memory, computes completion = max(left, up) +
// processing time (saturating at 2^25-1), writes it back into the previous
// row and emits one result item, the last machine marked with last. A
// schedule item is loaded, walks the machines through the read/modify/write
// loop on the row memory and then drains the final result; a stalled output
// holds the walk.
// first_job clears the previous row at once through per-entry valid bits,
// so no clearing pass is needed. machine_count 0 acts as 1, values above
// 32 act as 32. Results wait in an output register, so the next item can
// be taken while the final result of a schedule is still pending.
module flow_shop_makespan_evaluator
    import fsme_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input items
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_command,
    input  logic [JOB_ID_W-1:0]  i_job_id,
    input  logic [MACH_ID_W-1:0] i_machine_id,
    input  logic [PTIME_W-1:0]   i_proc_time,
    input  logic                 i_first_job,
    // result items
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [JOB_ID_W-1:0]  o_out_job,
    output logic [MACH_ID_W-1:0] o_out_machine,
    output logic [COMP_W-1:0]    o_completion_time,
    output logic                 o_last
);

    // control state
    t_state                  r_state, n_state;
    logic [MACH_W-1:0]       r_last_m;      // index of last machine in use
    logic [MACH_W-1:0]       r_m;           // machine being read
    logic [MACH_W-1:0]       r_s2_m;        // machine whose data is at ram outputs
    logic                    r_s2_valid;
    logic [MAX_MACHINES-1:0] r_valid;       // previous-row entry holds data
    logic [JOB_W-1:0]        r_job;
    logic [COMP_W-1:0]       r_left;        // completion on previous machine

    // output register
    logic                    r_out_valid;
    logic [JOB_ID_W-1:0]     r_out_job;
    logic [MACH_ID_W-1:0]    r_out_machine;
    logic [COMP_W-1:0]       r_out_time;
    logic                    r_out_last;

    // handshake and control decode
    logic in_acc;
    logic sched_acc;
    logic write_acc;
    logic adv;          // output slot free or emptying this cycle
    logic rd_en;
    logic cmp_en;

    // datapath
    logic [TIME_WIDTH-1:0] tt_rdata;
    logic [COMP_W-1:0]     row_rdata;
    logic [COMP_W-1:0]     up;
    logic [COMP_W-1:0]     mx;
    logic [COMP_W:0]       sum;
    logic [COMP_W-1:0]     comp;
    logic [MACH_W-1:0]     cfg_last;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign sched_acc = in_acc && (i_command == CMD_SCHED);
    assign write_acc = in_acc && (i_command == CMD_WRITE)
                     && ({1'b0, i_machine_id} < (MACH_ID_W+1)'(MAX_MACHINES));
    assign adv       = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (sched_acc) n_state = ST_WALK;
            end
            ST_WALK: begin
                if (adv && (r_m == r_last_m)) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (adv) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        rd_en      = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_in_stall = 1'b0;
            ST_WALK:  rd_en      = adv;
            ST_DRAIN: rd_en      = 1'b0;
            default:  o_in_stall = 1'b1;
        endcase
    end

    assign cmp_en = r_s2_valid && adv;

    // effective last machine index from machine_count
    always_comb begin
        priority if (i_cfg_data == '0) begin
            cfg_last = '0;
        end else if ({1'b0, i_cfg_data} > (CFG_W+1)'(MAX_MACHINES)) begin
            cfg_last = MACH_W'(MAX_MACHINES - 1);
        end else begin
            cfg_last = MACH_W'(i_cfg_data - CFG_W'(1));
        end
    end

    // processing time table, job-major
    fsme_ram #(
        .WIDTH (TIME_WIDTH),
        .DEPTH (TT_DEPTH)
    ) u_time_table (
        .i_clk   (i_clk),
        .i_we    (write_acc),
        .i_waddr ({i_job_id[JOB_W-1:0], i_machine_id[MACH_W-1:0]}),
        .i_wdata (i_proc_time[TIME_WIDTH-1:0]),
        .i_re    (rd_en),
        .i_raddr ({r_job, r_m}),
        .o_rdata (tt_rdata)
    );

    // completion times of the previous job; write of machine m and read of
    // machine m+1 fall in the same cycle, so the ports never collide
    fsme_ram #(
        .WIDTH (COMP_W),
        .DEPTH (MAX_MACHINES)
    ) u_prev_row (
        .i_clk   (i_clk),
        .i_we    (cmp_en),
        .i_waddr (r_s2_m),
        .i_wdata (comp),
        .i_re    (rd_en),
        .i_raddr (r_m),
        .o_rdata (row_rdata)
    );

    // relaxation step: max of left and up, add processing time, saturate
    assign up   = r_valid[r_s2_m] ? row_rdata : '0;
    assign mx   = (r_left > up) ? r_left : up;
    assign sum  = {1'b0, mx} + (COMP_W+1)'(tt_rdata);
    assign comp = sum[COMP_W] ? COMP_MAX : sum[COMP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_last_m    <= MACH_W'(MAX_MACHINES - 1);
            r_m         <= '0;
            r_s2_valid  <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_last_m <= cfg_last;
            end
            // issue pointer
            if (sched_acc) begin
                r_m <= '0;
            end else if (rd_en && (r_m != r_last_m)) begin
                r_m <= r_m + MACH_W'(1);
            end
            // read data in flight
            if (adv) begin
                r_s2_valid <= rd_en;
            end
            // previous-row validity; a new sequence drops the whole row
            if (sched_acc && i_first_job) begin
                r_valid <= '0;
            end else if (cmp_en) begin
                r_valid[r_s2_m] <= 1'b1;
            end
            // output register
            if (cmp_en) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (sched_acc) begin
            r_job  <= i_job_id[JOB_W-1:0];
            r_left <= '0;
        end else if (cmp_en) begin
            r_left <= comp;
        end
        if (rd_en) begin
            r_s2_m <= r_m;
        end
        if (cmp_en) begin
            r_out_job     <= JOB_ID_W'(r_job);
            r_out_machine <= MACH_ID_W'(r_s2_m);
            r_out_time    <= comp;
            r_out_last    <= (r_s2_m == r_last_m);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_job         = r_out_job;
    assign o_out_machine     = r_out_machine;
    assign o_completion_time = r_out_time;
    assign o_last            = r_out_last;

`ifndef ASSERT_OFF
    // no read data may be left over once the walk is done
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_s2_valid)
        else $error("read data pending while idle");

    // a read issued lands at the ram outputs tagged with its machine
    a_read_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |=> (r_s2_valid && (r_s2_m == $past(r_m))))
        else $error("read tag lost");

    // a new sequence starts from an empty previous row
    a_row_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sched_acc && i_first_job) |=> (r_valid == '0))
        else $error("previous row not cleared");

    // completion never falls along the machines of one job
    a_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmp_en && (r_s2_m != '0)) |-> (comp >= r_left))
        else $error("completion time decreased along the row");
`endif

endmodule
